// File: rtl/tobt_pkg.sv
package tobt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int PRICE_BITS  = 48;
    localparam int SLOT_BITS   = 6;
    localparam int IDX_BITS    = $clog2(TABLE_SLOTS + 1);
    localparam int VOL_BITS    = 48;
    localparam int BVOL_BITS   = VOL_BITS + 1;
    localparam int TIME_BITS   = 27;
    localparam int OP_BITS     = 2;
    localparam int CFG_BITS    = 11;

    localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FLUSH = 2'd2;

    typedef logic signed [PRICE_BITS-1:0] price_t;
    typedef logic [VOL_BITS-1:0]          vol_t;
    typedef logic signed [BVOL_BITS-1:0]  bvol_t;
    typedef logic [TIME_BITS-1:0]         time_t;
    typedef logic [SLOT_BITS-1:0]         slot_t;

    localparam int IN_FIELD_BITS  = SLOT_BITS + 4 * PRICE_BITS + 2 * TIME_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_PAD_BITS    = IN_DATA_BITS - IN_FIELD_BITS;
    localparam int OUT_FIELD_BITS = SLOT_BITS + 6 * PRICE_BITS + BVOL_BITS + 3 * TIME_BITS
                                    - 2 * PRICE_BITS + VOL_BITS * 0 + 2 * PRICE_BITS
                                    - 2 * PRICE_BITS + 2 * PRICE_BITS - PRICE_BITS * 0;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    // input request, first field in the lowest bits
    typedef struct packed {
        logic [IN_PAD_BITS-1:0] pad;
        time_t  trading_day;
        time_t  update_time_ms;
        price_t lower_limit;
        price_t upper_limit;
        vol_t   cum_volume;
        price_t trade_price;
        slot_t  ticker_slot;
    } in_t;

    // one table entry
    typedef struct packed {
        price_t open_p;
        price_t high_p;
        price_t low_p;
        price_t close_p;
        vol_t   start_vol;
        bvol_t  vol;
        time_t  first_t;
        time_t  latest_t;
        price_t lim_up;
        price_t lim_down;
        time_t  day;
    } bar_t;

    // emitted bar, first field in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_BITS:0] pad;
        time_t  day_out;
        price_t limit_down_out;
        price_t limit_up_out;
        time_t  end_time_ms;
        time_t  start_time_ms;
        bvol_t  bar_volume;
        price_t close_price;
        price_t low_price;
        price_t high_price;
        price_t open_price;
        slot_t  slot_out;
    } out_t;

    function automatic out_t make_out(input bar_t b, input slot_t s);
        out_t o;
        o.pad            = '0;
        o.day_out        = b.day;
        o.limit_down_out = b.lim_down;
        o.limit_up_out   = b.lim_up;
        o.end_time_ms    = b.latest_t;
        o.start_time_ms  = b.first_t;
        o.bar_volume     = b.vol;
        o.close_price    = b.close_p;
        o.low_price      = b.low_p;
        o.high_price     = b.high_p;
        o.open_price     = b.open_p;
        o.slot_out       = s;
        return o;
    endfunction

endpackage

// File: rtl/tick_to_ohlcv_bar_table_unit.sv
// ticks and clears: one request per cycle, read entry, merge next cycle and write back;
//   a tick that hits the entry written in the cycle before takes the forwarded bar
// flush: input stalls for the sweep, which steps over empty slots and reads each held bar
//   through the table memory read port, then at the table end emits the final bar
//   if there is one and clears the table; the sweep waits while the output is held off
// reset: all bars dropped (valid bits cleared), output idle, interval register = 1
module tick_to_ohlcv_bar_table_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tobt_pkg::CFG_BITS-1:0]        cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // ticker_slot, trade_price, cum_volume, upper_limit, lower_limit,
    // update_time_ms, trading_day, zero pad
    input  logic [tobt_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // opcode
    input  logic [tobt_pkg::OP_BITS-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // slot_out, open_price, high_price, low_price, close_price, bar_volume,
    // start_time_ms, end_time_ms, limit_up_out, limit_down_out, day_out
    output logic [tobt_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import tobt_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    bar_t mem [TABLE_SLOTS];

    logic [CFG_BITS-1:0]    interval_reg;
    logic [1:0]             state_reg, state_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic                   hold_full_reg, hold_full_next;
    out_t                   hold_reg, hold_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_reg, out_next;
    logic                   out_last_reg, out_last_next;
    logic [TABLE_SLOTS-1:0] valid_reg;

    logic                   st2_valid_reg;
    logic [OP_BITS-1:0]     st2_op_reg;
    in_t                    st2_tick_reg;
    logic                   wb_valid_reg;
    slot_t                  wb_slot_reg;
    bar_t                   wb_bar_reg;
    bar_t                   rd_data_reg;

    in_t                    in_word;
    logic                   accept;
    logic                   rd_en;
    slot_t                  rd_addr;
    slot_t                  idx_slot;
    logic                   we;
    logic                   slot_in_range;
    bar_t                   cur_bar;
    bar_t                   new_bar;
    logic                   out_free;
    logic                   sweep_clear;

    assign in_word       = in_t'(s_axis_tdata);
    assign s_axis_tready = (state_reg == ST_RUN);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign idx_slot      = idx_reg[SLOT_BITS-1:0];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign sweep_clear   = (state_reg == ST_DONE) && !hold_full_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_reg);
    assign m_axis_tlast  = out_last_reg;

    // interval is only stored on cfg_wr_en; nothing in the block reads it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= CFG_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            interval_reg <= cfg_wr_data;
        end
    end

    // read port: tick lookups while running, slot sweep during flush
    assign rd_en = (accept && s_axis_tuser == OP_TICK) ||
                   (state_reg == ST_SCAN && idx_reg != IDX_BITS'(TABLE_SLOTS) &&
                    valid_reg[idx_slot]);
    assign rd_addr = (state_reg == ST_RUN) ? in_word.ticker_slot : idx_slot;

    assign slot_in_range = {1'b0, st2_tick_reg.ticker_slot} < IDX_BITS'(TABLE_SLOTS);
    assign we = st2_valid_reg && st2_op_reg == OP_TICK && slot_in_range;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[st2_tick_reg.ticker_slot] <= new_bar;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // the read of the next tick overlaps the write of this one
    assign cur_bar = (wb_valid_reg && wb_slot_reg == st2_tick_reg.ticker_slot) ?
                     wb_bar_reg : rd_data_reg;

    tobt_bar_update u_update (
        .open_new (!valid_reg[st2_tick_reg.ticker_slot]),
        .cur      (cur_bar),
        .tick     (st2_tick_reg),
        .nxt      (new_bar)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st2_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            st2_valid_reg <= accept && s_axis_tuser != OP_FLUSH;
            wb_valid_reg  <= we;
            if ((st2_valid_reg && st2_op_reg == OP_CLEAR) || sweep_clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[st2_tick_reg.ticker_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st2_op_reg   <= s_axis_tuser;
            st2_tick_reg <= in_word;
        end
        if (we)
        begin
            wb_slot_reg <= st2_tick_reg.ticker_slot;
            wb_bar_reg  <= new_bar;
        end
    end

    // flush sweep: a found bar waits in the hold register until the next one
    // shows up or the sweep ends, which tells whether it is the final one
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hold_full_next = hold_full_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_RUN:
            begin
                if (accept && s_axis_tuser == OP_FLUSH)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == IDX_BITS'(TABLE_SLOTS))
                begin
                    state_next = ST_DONE;
                end
                else if (valid_reg[idx_slot])
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                if (!hold_full_reg || out_free)
                begin
                    if (hold_full_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                        out_last_next  = 1'b0;
                    end
                    hold_next      = make_out(rd_data_reg, idx_slot);
                    hold_full_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                if (hold_full_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                        out_last_next  = 1'b1;
                        hold_full_next = 1'b0;
                    end
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            idx_reg       <= '0;
            hold_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hold_full_reg <= hold_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    a_hold_only_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> !hold_full_reg)
        else $error("held bar outside a flush sweep");

    a_flush_clears_table: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_clear |=> valid_reg == '0 && state_reg == ST_RUN)
        else $error("table not empty after flush");

    a_tick_opens_slot: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> valid_reg[$past(st2_tick_reg.ticker_slot)])
        else $error("written slot not marked valid");

    a_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_BITS'(TABLE_SLOTS))
        else $error("sweep index past table end");

    a_no_stage_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_READ) |-> !st2_valid_reg && !we)
        else $error("table update during flush sweep");

    a_interval_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> interval_reg == $past(cfg_wr_data))
        else $error("interval register lost a write");

endmodule

// File: rtl/tobt_bar_update.sv
module tobt_bar_update (
    input  logic           open_new,
    input  tobt_pkg::bar_t cur,
    input  tobt_pkg::in_t  tick,
    output tobt_pkg::bar_t nxt
);
    import tobt_pkg::*;

    always_comb
    begin
        if (open_new)
        begin
            nxt.open_p    = tick.trade_price;
            nxt.high_p    = tick.trade_price;
            nxt.low_p     = tick.trade_price;
            nxt.close_p   = tick.trade_price;
            nxt.start_vol = tick.cum_volume;
            nxt.vol       = '0;
            nxt.first_t   = tick.update_time_ms;
            nxt.latest_t  = tick.update_time_ms;
            nxt.lim_up    = tick.upper_limit;
            nxt.lim_down  = tick.lower_limit;
            nxt.day       = tick.trading_day;
        end
        else
        begin
            nxt          = cur;
            nxt.close_p  = tick.trade_price;
            nxt.latest_t = tick.update_time_ms;
            if (tick.trade_price < cur.low_p)
            begin
                nxt.low_p = tick.trade_price;
            end
            if (cur.high_p < tick.trade_price)
            begin
                nxt.high_p = tick.trade_price;
            end
            // gives a negative bar volume when the cumulative volume goes down
            nxt.vol = $signed({1'b0, tick.cum_volume} - {1'b0, cur.start_vol});
        end
    end

endmodule

// File: tb/tb_tick_to_ohlcv_bar_table_unit.sv
`timescale 1ns / 1ps

module tb_tick_to_ohlcv_bar_table_unit;
    import tobt_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 2 * TABLE_SLOTS + 16;
    localparam int RX_HOLD_CYCLES = 300;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    localparam price_t PRICE_MAX   = {1'b0, {(PRICE_BITS-1){1'b1}}};
    localparam price_t PRICE_MIN   = {1'b1, {(PRICE_BITS-1){1'b0}}};
    localparam vol_t   VOL_MAX     = '1;
    localparam time_t  TIME_MAX_MS = 27'd86399999;
    localparam time_t  DAY_MAX     = 27'd99999999;

    // bar fields on m_axis_tdata, lowest bit up
    localparam int O_OPEN  = SLOT_BITS;
    localparam int O_HIGH  = O_OPEN + PRICE_BITS;
    localparam int O_LOW   = O_HIGH + PRICE_BITS;
    localparam int O_CLOSE = O_LOW + PRICE_BITS;
    localparam int O_VOL   = O_CLOSE + PRICE_BITS;
    localparam int O_START = O_VOL + BVOL_BITS;
    localparam int O_END   = O_START + TIME_BITS;
    localparam int O_LIMUP = O_END + TIME_BITS;
    localparam int O_LIMDN = O_LIMUP + PRICE_BITS;
    localparam int O_DAY   = O_LIMDN + PRICE_BITS;

    typedef struct {
        slot_t  slot;
        price_t open_p;
        price_t high_p;
        price_t low_p;
        price_t close_p;
        bvol_t  vol;
        time_t  start_t;
        time_t  end_t;
        price_t lim_up;
        price_t lim_dn;
        time_t  day;
        logic   last;
    } bar_rec_t;

    class bar_scoreboard;
        logic [CFG_BITS-1:0] interval_min;
        bit                  held[TABLE_SLOTS];
        bar_rec_t            bars[TABLE_SLOTS];
        vol_t                start_vol[TABLE_SLOTS];
        bar_rec_t            due_bars[$];
        int                  errors;

        function new();
            interval_min = 1;
            errors = 0;
            foreach (held[i])
                held[i] = 1'b0;
        endfunction

        function void note_interval(logic [CFG_BITS-1:0] v);
            interval_min = v;
        endfunction

        function void note_request(logic [OP_BITS-1:0] op, in_t d);
            slot_t                s;
            price_t               px;
            logic [BVOL_BITS-1:0] diff;
            bar_rec_t             b;
            int                   n;
            int                   k;
            s = d.ticker_slot;
            px = d.trade_price;
            case (op)
                OP_TICK:
                begin
                    if (int'(s) < TABLE_SLOTS)
                    begin
                        if (!held[s])
                        begin
                            held[s] = 1'b1;
                            bars[s].slot = s;
                            bars[s].day = d.trading_day;
                            bars[s].lim_up = d.upper_limit;
                            bars[s].lim_dn = d.lower_limit;
                            bars[s].start_t = d.update_time_ms;
                            bars[s].end_t = d.update_time_ms;
                            bars[s].open_p = px;
                            bars[s].close_p = px;
                            bars[s].low_p = px;
                            bars[s].high_p = px;
                            bars[s].vol = '0;
                            bars[s].last = 1'b0;
                            start_vol[s] = d.cum_volume;
                        end
                        else
                        begin
                            bars[s].end_t = d.update_time_ms;
                            bars[s].close_p = px;
                            if (px < bars[s].low_p)
                                bars[s].low_p = px;
                            if (px > bars[s].high_p)
                                bars[s].high_p = px;
                            diff = {1'b0, d.cum_volume} - {1'b0, start_vol[s]};
                            bars[s].vol = $signed(diff);
                        end
                    end
                end
                OP_CLEAR:
                begin
                    foreach (held[i])
                        held[i] = 1'b0;
                end
                OP_FLUSH:
                begin
                    n = 0;
                    foreach (held[i])
                        if (held[i])
                            n++;
                    k = 0;
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (held[i])
                        begin
                            k++;
                            b = bars[i];
                            b.last = (k == n);
                            due_bars.insert(due_bars.size(), b);
                            held[i] = 1'b0;
                        end
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void cmp(string name, logic signed [63:0] e, logic signed [63:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_bar(logic [OUT_DATA_BITS-1:0] d, logic last);
            bar_rec_t e;
            if (due_bars.size() == 0)
            begin
                errors++;
                $display("%0t: bar with none expected, expected nothing actual slot %0d",
                         $time, d[SLOT_BITS-1:0]);
                return;
            end
            e = due_bars.pop_front();
            cmp("slot_out", e.slot, slot_t'(d[SLOT_BITS-1:0]));
            cmp("open_price", e.open_p, price_t'(d[O_OPEN +: PRICE_BITS]));
            cmp("high_price", e.high_p, price_t'(d[O_HIGH +: PRICE_BITS]));
            cmp("low_price", e.low_p, price_t'(d[O_LOW +: PRICE_BITS]));
            cmp("close_price", e.close_p, price_t'(d[O_CLOSE +: PRICE_BITS]));
            cmp("bar_volume", e.vol, bvol_t'(d[O_VOL +: BVOL_BITS]));
            cmp("start_time_ms", e.start_t, time_t'(d[O_START +: TIME_BITS]));
            cmp("end_time_ms", e.end_t, time_t'(d[O_END +: TIME_BITS]));
            cmp("limit_up_out", e.lim_up, price_t'(d[O_LIMUP +: PRICE_BITS]));
            cmp("limit_down_out", e.lim_dn, price_t'(d[O_LIMDN +: PRICE_BITS]));
            cmp("day_out", e.day, time_t'(d[O_DAY +: TIME_BITS]));
            cmp("last", e.last, last);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_BITS-1:0]      cfg_wr_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    // ticker_slot, trade_price, cum_volume, upper_limit, lower_limit,
    // update_time_ms, trading_day, zero pad
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    // opcode
    logic [OP_BITS-1:0]       s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    // slot_out, open_price, high_price, low_price, close_price, bar_volume,
    // start_time_ms, end_time_ms, limit_up_out, limit_down_out, day_out
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tlast;

    bar_scoreboard sb = new();

    int     tx_idle_pct;
    int     rx_idle_pct;
    bit     rx_hold_req;
    int     stall_cycles = 0;
    slot_t  pool[8];
    price_t px_walk[TABLE_SLOTS];
    vol_t   vol_walk[TABLE_SLOTS];

    tick_to_ohlcv_bar_table_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bars are checked before the request of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_bar(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // bar receiver, with one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_req = 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic price_t rand_wide();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[PRICE_BITS-1:0];
    endfunction

    function automatic in_t make_fields(slot_t s, price_t px, vol_t v, price_t up,
                                        price_t dn, time_t t, time_t day);
        in_t d;
        d = '0;
        d.ticker_slot = s;
        d.trade_price = px;
        d.cum_volume = v;
        d.upper_limit = up;
        d.lower_limit = dn;
        d.update_time_ms = t;
        d.trading_day = day;
        return d;
    endfunction

    task automatic send_request(input logic [OP_BITS-1:0] op, input in_t d);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // random content; prices walk per slot, volume mostly grows
    task automatic send_item(input logic [OP_BITS-1:0] op, input slot_t s);
        int   delta;
        in_t  d;
        delta = int'($urandom_range(0, 2000)) - 1000;
        if ($urandom_range(0, 9) == 0)
            px_walk[s] = rand_wide();
        else
            px_walk[s] = px_walk[s] + price_t'(delta);
        case ($urandom_range(0, 9))
            0: vol_walk[s] = rand_wide();
            1: vol_walk[s] = vol_walk[s] - vol_t'($urandom_range(0, 5000));
            default: vol_walk[s] = vol_walk[s] + vol_t'($urandom_range(0, 100000));
        endcase
        d = make_fields(s, px_walk[s], vol_walk[s], rand_wide(), rand_wide(),
                        time_t'($urandom_range(0, TIME_MAX_MS)),
                        time_t'($urandom_range(0, DAY_MAX)));
        send_request(op, d);
    endtask

    task automatic pick_pool();
        foreach (pool[i])
            pool[i] = slot_t'($urandom_range(0, TABLE_SLOTS - 1));
    endtask

    task automatic run_random(input int count);
        int    done_n;
        int    r;
        slot_t s;
        done_n = 0;
        while (done_n < count)
        begin
            r = $urandom_range(0, 99);
            s = pool[$urandom_range(0, 7)];
            if (r < 8)
                send_item(OP_FLUSH, s);
            else if (r < 11)
                send_item(OP_CLEAR, s);
            else if (r < 13)
            begin
                // ignored by the block, not counted
                send_item(OP_UNUSED, s);
                continue;
            end
            else if (r < 22)
                send_item(OP_TICK, slot_t'($urandom_range(0, TABLE_SLOTS - 1)));
            else
                send_item(OP_TICK, s);
            done_n++;
        end
    endtask

    // drop valid, let all bars drain, then let the block settle
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.due_bars.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_interval(input logic [CFG_BITS-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.note_interval(v);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        m_axis_tready = 1'b0;
        rx_hold_req = 1'b0;
        foreach (px_walk[i])
        begin
            px_walk[i] = price_t'(int'($urandom_range(0, 2000000)) - 1000000);
            vol_walk[i] = vol_t'($urandom);
        end
        tx_idle_pct = 28;
        rx_idle_pct = 78;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_interval(11'd1440);

        // extremes, volume going down, ignored opcode, a flush of held bars, empty flushes
        send_request(OP_TICK, make_fields(0, PRICE_MAX, '0, PRICE_MAX, PRICE_MIN, 0, 0));
        send_request(OP_TICK, make_fields(0, PRICE_MIN, VOL_MAX, PRICE_MIN, PRICE_MAX,
                                          TIME_MAX_MS, DAY_MAX));
        send_request(OP_TICK, make_fields(0, 0, VOL_MAX, 0, 0, 1, 1));
        send_request(OP_TICK, make_fields(63, -1, VOL_MAX, PRICE_MIN, PRICE_MAX,
                                          TIME_MAX_MS, DAY_MAX));
        send_request(OP_TICK, make_fields(63, 1, '0, PRICE_MAX, PRICE_MIN, 0, 0));
        send_request(OP_UNUSED, make_fields(5, PRICE_MAX, VOL_MAX, PRICE_MAX, PRICE_MAX,
                                            TIME_MAX_MS, DAY_MAX));
        send_request(OP_FLUSH, make_fields(63, PRICE_MAX, VOL_MAX, PRICE_MIN, PRICE_MIN,
                                           TIME_MAX_MS, DAY_MAX));
        send_request(OP_FLUSH, make_fields(0, 0, 0, 0, 0, 0, 0));
        send_request(OP_TICK, make_fields(10, 500, 100, 900, 100, 1000, 20240102));
        send_request(OP_TICK, make_fields(20, -500, 100, 900, 100, 1000, 20240102));
        send_request(OP_CLEAR, make_fields(20, 0, 0, 0, 0, 0, 0));
        send_request(OP_FLUSH, make_fields(0, 0, 0, 0, 0, 0, 0));
        // same slot back to back, then another slot in between
        send_request(OP_TICK, make_fields(30, 1000, 50, 2000, 10, 100, 20240103));
        send_request(OP_TICK, make_fields(30, 1500, 70, 0, 0, 200, 0));
        send_request(OP_TICK, make_fields(30, 900, 90, 0, 0, 300, 0));
        send_request(OP_TICK, make_fields(31, -7, 5, -1, -9, 400, 20240103));
        send_request(OP_TICK, make_fields(30, 1200, 40, 0, 0, 500, 0));
        send_request(OP_TICK, make_fields(31, -3, 2, 0, 0, 600, 0));
        send_request(OP_FLUSH, make_fields(0, 0, 0, 0, 0, 0, 0));

        pick_pool();
        run_random(25);
        wait_quiet();
        write_interval(11'd1);

        tx_idle_pct = 78;
        rx_idle_pct = 28;
        pick_pool();
        run_random(25);
        wait_quiet();
        write_interval(11'($urandom_range(2, 1439)));

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pick_pool();
        repeat (20) send_item(OP_TICK, slot_t'($urandom_range(0, TABLE_SLOTS - 1)));
        // receiver stops while the flush sweeps, input backs up
        rx_hold_req = 1'b1;
        send_item(OP_FLUSH, pool[0]);
        run_random(25);
        wait_quiet();

        if (sb.errors == 0 && sb.due_bars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
